/* rtl/kphq_pkg.sv */
// shared constants and types of the knob position hysteresis quantizer
package kphq_pkg;

    localparam int RING_DEPTH = 20;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 9;
    localparam int INDEX_W    = 8;
    localparam int DIV_W      = 12;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int SUM_W      = $clog2(RING_DEPTH * 4095 + 1);

    // mean by reciprocal multiply, exact for every sum below 2**SUM_W
    localparam int RECIP_SHIFT = SUM_W + $clog2(RING_DEPTH);
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(RING_DEPTH) + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    localparam logic [PTR_W-1:0]     PTR_LAST    = PTR_W'(RING_DEPTH - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(DIV_W - 1);
    localparam logic [DIV_W-1:0]     FULL_SCALE  = 12'd4095;
    localparam logic [COUNT_W-1:0]   MAX_CYCLES  = 9'd256;
    localparam logic [COUNT_W-1:0]   COUNT_RESET = 9'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_AVG,
        ST_DIV_WAIT,
        ST_QUANT,
        ST_STEP_START,
        ST_STEP_WAIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/knob_position_hysteresis_quantizer.sv */
// top level of the knob position hysteresis quantizer
//
// Each item is one 12-bit knob reading. It replaces the oldest of 20 ring
// entries, the ring sum is updated and its truncated mean is quantized to a
// cycle index with bins of 4095 / cycle_count, with hysteresis around the held
// index and a clamp to cycle_count - 1. One result item per input item:
// index, a changed flag (set on the first result after reset) and the mean.
// An item passes through these steps, from its accepting cycle to the earliest
// next accept: the ring memory read, the sum update, the mean multiply and the
// divider start, the wait on the shared restoring divider that computes
// mean / step (a 12-bit quotient, then its done flag), and the hysteresis
// decision. A finished result waits in the output register, so the next item
// is taken while it is still unread; the decision of that next item then waits
// until the register frees up. A write to cycle_count recomputes the bin step
// with the same divider, which holds s_tready low until it is done.
// The ring resets through per-entry valid bits, so there is no clearing pass
// after reset.
module knob_position_hysteresis_quantizer (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: cycle_count
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_sample, [15:12] zero
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] selected cycle, [8] index_changed,
                                   // [20:9] averaged_value, [23:21] zero
);
    import kphq_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int HPROD_W = INDEX_W + DIV_W;

    state_t state_reg, state_next;

    // configuration and derived bin step
    logic [COUNT_W-1:0] cycle_count_reg;
    logic [COUNT_W-1:0] eff_count;
    logic [DIV_W-1:0]   step_reg;
    logic               step_stale_reg;

    // sample ring: memory plus one valid bit per entry
    logic [SAMPLE_W-1:0]   ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] ring_valid_reg;
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  rd_valid_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [PTR_W-1:0]      wp_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SAMPLE_W-1:0]   old_sample;

    // average and hysteresis datapath
    logic [PROD_W-1:0]    avg_prod_reg;
    logic [HPROD_W-1:0]   hprod_reg;
    logic [SAMPLE_W-1:0]  avg_reg;
    logic [HPROD_W:0]     mid_reg;
    logic [HPROD_W+1:0]   next_mid_reg;
    logic [INDEX_W-1:0]   held_reg;
    logic [INDEX_W-1:0]   last_reg;
    logic                 emitted_valid_reg;
    logic [DIV_W-2:0]     half;

    // divider hookup
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    logic [DIV_W-1:0]     div_quot;
    div_status_t          div_status;

    // decision
    logic                 sel_raw;
    logic [DIV_W-1:0]     held_ext;
    logic [DIV_W-1:0]     sel_wide;
    logic [INDEX_W-1:0]   sel;
    logic                 changed;
    logic                 out_free;
    logic                 out_load;

    // output register
    logic                 m_tvalid_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic                 out_changed_reg;
    logic [SAMPLE_W-1:0]  out_avg_reg;

    kphq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .status   (div_status)
    );

    // zero means one, anything past 256 saturates
    always_comb begin
        if (cycle_count_reg == '0) begin
            eff_count = COUNT_RESET;
        end else if (cycle_count_reg > MAX_CYCLES) begin
            eff_count = MAX_CYCLES;
        end else begin
            eff_count = cycle_count_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (step_stale_reg) begin
                    state_next = ST_STEP_START;
                end else if (s_tvalid) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:      state_next = ST_MUL;
            ST_MUL:      state_next = ST_AVG;
            ST_AVG:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_status.done) begin
                    state_next = ST_QUANT;
                end
            end
            ST_QUANT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP_START: state_next = ST_STEP_WAIT;
            ST_STEP_WAIT: begin
                if (step_stale_reg) begin
                    state_next = ST_STEP_START;
                end else if (div_status.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = FULL_SCALE;
        div_divisor  = DIV_W'(eff_count);
        unique case (state_reg)
            ST_IDLE:       s_tready = !step_stale_reg;
            ST_STEP_START: div_start = 1'b1;
            ST_AVG: begin
                div_start    = 1'b1;
                div_dividend = avg_prod_reg[RECIP_SHIFT +: SAMPLE_W];
                div_divisor  = step_reg;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration register and bin step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_count_reg <= COUNT_RESET;
            step_stale_reg  <= 1'b0;
            step_reg        <= FULL_SCALE;
        end else begin
            if (cfg_we) begin
                cycle_count_reg <= cfg_wdata;
            end
            step_stale_reg <= cfg_we || (step_stale_reg && state_reg != ST_STEP_START);
            if (state_reg == ST_STEP_WAIT && div_status.done && !step_stale_reg) begin
                step_reg <= div_quot;
            end
        end
    end

    // ring memory, read on accept and written back in the cycle after
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            rd_data_reg <= ring_mem[wp_reg];
            sample_reg  <= s_tdata[SAMPLE_W-1:0];
        end
        if (state_reg == ST_SUM) begin
            ring_mem[wp_reg] <= sample_reg;
        end
    end

    assign old_sample = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            wp_reg         <= '0;
            sum_reg        <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                rd_valid_reg <= ring_valid_reg[wp_reg];
            end
            if (state_reg == ST_SUM) begin
                ring_valid_reg[wp_reg] <= 1'b1;
                sum_reg <= sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                wp_reg  <= (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
            end
        end
    end

    assign half = step_reg[DIV_W-1:1];

    // mean by reciprocal, bin midpoints around the held index
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            avg_prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
            hprod_reg    <= HPROD_W'(held_reg) * HPROD_W'(step_reg);
        end
        if (state_reg == ST_AVG) begin
            avg_reg      <= avg_prod_reg[RECIP_SHIFT +: SAMPLE_W];
            mid_reg      <= (HPROD_W+1)'(hprod_reg) + (HPROD_W+1)'(half);
            next_mid_reg <= (HPROD_W+2)'(hprod_reg) + (HPROD_W+2)'(half)
                          + (HPROD_W+2)'(step_reg);
        end
    end

    // hysteresis: follow the raw index only past a neighbor's midpoint
    always_comb begin
        held_ext = DIV_W'(held_reg);
        if (div_quot == held_ext) begin
            sel_raw = 1'b1;
        end else if ((HPROD_W+1)'(avg_reg) > mid_reg) begin
            sel_raw = (HPROD_W+2)'(avg_reg) >= next_mid_reg;
        end else if ((HPROD_W+1)'(avg_reg) < mid_reg) begin
            // mean below held*step - half, kept unsigned
            sel_raw = ((HPROD_W+1)'(avg_reg) + (HPROD_W+1)'(half))
                    < (HPROD_W+1)'(hprod_reg);
        end else begin
            sel_raw = 1'b0;
        end
        sel_wide = sel_raw ? div_quot : held_ext;
        if (sel_wide >= DIV_W'(eff_count)) begin
            sel = INDEX_W'(eff_count - 1'b1);
        end else begin
            sel = sel_wide[INDEX_W-1:0];
        end
        changed = !emitted_valid_reg || (sel != last_reg);
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_QUANT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg          <= '0;
            last_reg          <= '0;
            emitted_valid_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (out_load) begin
                held_reg     <= sel;
                m_tvalid_reg <= 1'b1;
                if (changed) begin
                    last_reg          <= sel;
                    emitted_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_index_reg   <= sel;
            out_changed_reg <= changed;
            out_avg_reg     <= avg_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_avg_reg, out_changed_reg, out_index_reg};

`ifndef SYNTH
    // divider completes only for a pass that the sequencer started
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIV_WAIT || state_reg == ST_STEP_WAIT
                             || state_reg == ST_STEP_START))
        else $error("divider done outside a division pass");

    // write pointer stays inside the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= PTR_LAST)
        else $error("ring write pointer out of range");

    // emitted index respects the clamp of the count in force
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> ({1'b0, m_tdata[7:0]} < $past(eff_count)))
        else $error("cycle index not below cycle count");

    // a result appears only from the decision state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_QUANT))
        else $error("result raised outside the decision state");
`endif

endmodule

/* rtl/kphq_div.sv */
// restoring divider, one quotient bit per cycle
module kphq_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [kphq_pkg::DIV_W-1:0] dividend,
    input  logic [kphq_pkg::DIV_W-1:0] divisor,
    output logic [kphq_pkg::DIV_W-1:0] quotient,
    output kphq_pkg::div_status_t      status
);
    import kphq_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [DIV_W-1:0] rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // quotient bits shift in where the dividend shifts out
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* tb/testbench.sv */
// testbench of the knob position hysteresis quantizer: random knob readings, scoreboard check
`timescale 1ns / 100ps

typedef struct packed {
    logic [kphq_pkg::SAMPLE_W-1:0] averaged_value;
    logic                          index_changed;
    logic [kphq_pkg::INDEX_W-1:0]  cycle_sel;
} knob_result_t;

// keeps its own copy of the ring, the held index and cycle_count
class knob_scoreboard;
    logic [kphq_pkg::SAMPLE_W-1:0] ring_entries [kphq_pkg::RING_DEPTH];
    int unsigned                   wr_ptr;
    logic [kphq_pkg::SUM_W-1:0]    ring_sum;
    logic [kphq_pkg::INDEX_W-1:0]  held_index;
    logic [kphq_pkg::INDEX_W-1:0]  last_index;
    bit                            emitted_valid;
    logic [kphq_pkg::COUNT_W-1:0]  cycle_count;
    knob_result_t                  expected_results [$];
    int unsigned                   failures;

    function new();
        foreach (ring_entries[i]) ring_entries[i] = '0;
        wr_ptr        = 0;
        ring_sum      = '0;
        held_index    = '0;
        last_index    = '0;
        emitted_valid = 0;
        cycle_count   = kphq_pkg::COUNT_RESET;
        failures      = 0;
    endfunction

    function void write_count(logic [kphq_pkg::COUNT_W-1:0] value);
        cycle_count = value;
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    // predicts the result of one accepted reading
    function void note_sample(logic [kphq_pkg::SAMPLE_W-1:0] adc_sample);
        int unsigned  eff;
        int unsigned  mean;
        int unsigned  bin_step;
        int unsigned  half;
        int unsigned  raw;
        int unsigned  sel;
        int           held_mid;
        int           next_mid;
        int           prev_mid;
        knob_result_t res;
        if (cycle_count == 0)
            eff = 1;
        else if (cycle_count > kphq_pkg::MAX_CYCLES)
            eff = kphq_pkg::MAX_CYCLES;
        else
            eff = cycle_count;

        ring_sum = ring_sum - ring_entries[wr_ptr] + adc_sample;
        ring_entries[wr_ptr] = adc_sample;
        wr_ptr = (wr_ptr == kphq_pkg::RING_DEPTH - 1) ? 0 : wr_ptr + 1;

        mean = ring_sum / kphq_pkg::RING_DEPTH;
        if (mean > kphq_pkg::FULL_SCALE) mean = kphq_pkg::FULL_SCALE;

        // hysteresis around the held bin; signed compares keep a negative
        // lower midpoint out of reach
        bin_step = kphq_pkg::FULL_SCALE / eff;
        half     = bin_step / 2;
        raw      = mean / bin_step;
        sel      = held_index;
        if (raw == held_index) begin
            sel = raw;
        end else begin
            held_mid = int'(held_index) * int'(bin_step) + int'(half);
            if (int'(mean) > held_mid) begin
                next_mid = (int'(held_index) + 1) * int'(bin_step) + int'(half);
                if (int'(mean) >= next_mid) sel = raw;
            end else if (int'(mean) < held_mid) begin
                prev_mid = int'(held_index) * int'(bin_step) - int'(half);
                if (int'(mean) < prev_mid) sel = raw;
            end
        end
        if (sel >= eff) sel = eff - 1;
        held_index = sel[kphq_pkg::INDEX_W-1:0];

        res.cycle_sel      = sel[kphq_pkg::INDEX_W-1:0];
        res.index_changed  = !emitted_valid || (held_index != last_index);
        res.averaged_value = mean[kphq_pkg::SAMPLE_W-1:0];
        if (res.index_changed) begin
            last_index    = held_index;
            emitted_valid = 1;
        end
        expected_results.push_back(res);
    endfunction

    function void check_result(logic [23:0] data);
        knob_result_t got;
        knob_result_t want;
        got = data[$bits(knob_result_t)-1:0];
        if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: result with nothing expected: index %0d changed %0d mean %0d",
                         $realtime, got.cycle_sel, got.index_changed, got.averaged_value);
            return;
        end
        want = expected_results.pop_front();
        if (got.cycle_sel != want.cycle_sel || got.index_changed != want.index_changed ||
            got.averaged_value != want.averaged_value) begin
            failures++;
            if (failures <= 10)
                $display("%0t: mismatch: index %0d/%0d changed %0d/%0d mean %0d/%0d (exp/act)",
                         $realtime, want.cycle_sel, got.cycle_sel, want.index_changed,
                         got.index_changed, want.averaged_value, got.averaged_value);
        end
    endfunction

    function void close_out();
        if (expected_results.size() != 0) begin
            failures++;
            $display("%0d expected results never arrived", expected_results.size());
        end
    endfunction
endclass

module testbench;

    localparam int RANDOM_ITEMS = 1150;
    localparam int STALL_LIMIT  = 2000;   // cycles without any handshake
    localparam int TAIL_CYCLES  = 40;     // idle tail after the final drain

    typedef enum {
        SHAPE_UNIFORM,
        SHAPE_WALK,
        SHAPE_EDGE_DWELL,
        SHAPE_RAILS
    } knob_shape_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    knob_scoreboard sb;
    bit             no_idle;      // both sides run without gaps in this stretch
    int unsigned    quiet_cycles;

    knob_position_hysteresis_quantizer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // called just after a falling edge, returns just after one
    task automatic send_reading(input logic [11:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, value};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // only written with nothing in flight
    task automatic write_cycle_count(input logic [8:0] value);
        drain_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // scoreboard hookup, everything sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sb.write_count(cfg_wdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready) sb.note_sample(s_tdata[11:0]);
        end
    end

    // watchdog: too long without any handshake or register write
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall before each item
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        int          sent;
        int          phase_len;
        int          pick;
        int          eff;
        int          bin_step;
        int          knob_pos;
        int          centre;
        int          value;
        logic [8:0]  count_value;
        knob_shape_t shape;

        sb           = new();
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        no_idle      = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset count first, both rails
        send_reading(12'd0);
        send_reading(12'd4095);
        // largest count, ring filled at full scale runs the raw index past the end
        write_cycle_count(9'd256);
        repeat (20) send_reading(12'd4095);
        // zero count acts as one
        write_cycle_count(9'd0);
        send_reading(12'hAAA);
        // count above range saturates
        write_cycle_count(9'd511);
        send_reading(12'h555);

        // random phases, each under its own cycle_count
        sent     = 0;
        knob_pos = $urandom_range(0, 4095);
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: count_value = 9'd0;
                1: count_value = 9'd1;
                2: count_value = 9'd2;
                3: count_value = 9'd256;
                4: count_value = 9'd257;
                5: count_value = 9'd511;
                6, 7: count_value = 9'($urandom_range(1, 16));
                default: count_value = 9'($urandom_range(1, 256));
            endcase
            write_cycle_count(count_value);
            eff      = (count_value == 0) ? 1 : (count_value > 256) ? 256 : int'(count_value);
            bin_step = 4095 / eff;
            no_idle  = ($urandom_range(0, 3) == 0);
            shape    = knob_shape_t'($urandom_range(0, 3));
            centre   = $urandom_range(0, eff) * bin_step;
            phase_len = $urandom_range(40, 120);
            if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
            repeat (phase_len) begin
                case (shape)
                    SHAPE_UNIFORM: value = $urandom_range(0, 4095);
                    SHAPE_WALK: begin
                        // slow knob turn, crosses bins back and forth
                        knob_pos = knob_pos + $urandom_range(0, 80) - 40;
                        value    = knob_pos;
                    end
                    SHAPE_EDGE_DWELL: begin
                        // noise around one bin boundary
                        value = centre + $urandom_range(0, bin_step) - bin_step / 2;
                    end
                    default: value = ($urandom_range(0, 1) == 1) ? 4095 : 0;
                endcase
                if (value < 0) value = 0;
                if (value > 4095) value = 4095;
                if (shape == SHAPE_WALK) knob_pos = value;
                send_reading(12'(value));
                sent++;
                // now and then let everything in flight come out first
                if ($urandom_range(0, 59) == 0) drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        sb.close_out();
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
